/* sv/assert_macros.svh */
// Assertion macros shared by the filter RTL.
// Each macro expects clk_i and rst_ni in scope; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tlnef_pkg.sv */
// Types and constants of the line-number and escape filter.
// Used by the top level, front end, back end and testbench; depends on nothing.
package tlnef_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUMBER_NONBLANK  = 3'd0,
    CFG_NUMBER_ALL       = 3'd1,
    CFG_SHOW_ENDS        = 3'd2,
    CFG_SHOW_TABS        = 3'd3,
    CFG_SQUEEZE_BLANK    = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic show_ends;
    logic show_tabs;
    logic squeeze_blank;
    logic show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // How the byte itself is rendered.
  typedef enum logic [1:0] {
    CH_NONE  = 2'd0,
    CH_RAW   = 2'd1,
    CH_CARET = 2'd2,
    CH_META  = 2'd3
  } char_kind_e;

  // Command passed from the classifier to the expander.
  typedef struct packed {
    logic       numbered;
    logic       dollar;
    char_kind_e kind;
    logic [7:0] payload;
  } cmd_ctrl_t;

  localparam logic [7:0] ChTab     = 8'd9;
  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChSpace   = 8'd32;
  localparam logic [7:0] ChDollar  = 8'd36;
  localparam logic [7:0] ChDash    = 8'd45;
  localparam logic [7:0] ChZero    = 8'd48;
  localparam logic [7:0] ChQuery   = 8'd63;
  localparam logic [7:0] ChUpperM  = 8'd77;
  localparam logic [7:0] ChCaret   = 8'd94;
  localparam logic [7:0] CtrlMax   = 8'd31;
  localparam logic [7:0] ChDelete  = 8'd127;
  localparam logic [7:0] MetaMax   = 8'd159;
  localparam logic [7:0] CaretOfs  = 8'd64;

  localparam logic [3:0] BcdNine   = 4'd9;

endpackage

/* sv/text_line_number_escape_filter_unit.sv */
// Top level of the line-number and escape filter.
// Depends on tlnef_pkg, tlnef_front, tlnef_fifo and tlnef_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------
//   input   | in        | push / full        | in_item_i  (in_byte, new_file)
//   result  | out       | pop / empty        | out_item_o (out_byte, last)
//   config  | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// An input byte is classified in the cycle it is taken; the expander then emits
// its results in order (0 to NUMBER_DIGITS + 5 per item), taking the next item
// after the last. Single-result items stream at one per cycle while out_full is low.
// A two-entry command queue and a two-entry result queue let each side stall alone.
// Reset clears both queues, the configuration and the line state; no clearing pass.
module text_line_number_escape_filter_unit #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tlnef_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tlnef_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  tlnef_pkg::in_item_t              in_item_i,
  output logic                             empty,
  input  logic                             pop,
  output tlnef_pkg::out_item_t             out_item_o
);
  import tlnef_pkg::*;

  localparam int unsigned DigW = 4 * NUMBER_DIGITS;
  localparam int unsigned CmdW = $bits(cmd_ctrl_t) + DigW;
  localparam int unsigned OutW = $bits(out_item_t);

  logic             cmd_wr, cmd_full, cmd_empty, cmd_pop;
  cmd_ctrl_t        front_ctrl, back_ctrl;
  logic [DigW-1:0]  front_digits, back_digits;
  logic [CmdW-1:0]  cmd_rd_data;
  logic             out_wr, out_full;
  out_item_t        back_item;
  logic [OutW-1:0]  out_rd_data;

  tlnef_front #(
    .NumberDigits(NUMBER_DIGITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (push),
    .in_item_i    (in_item_i),
    .cmd_full_i   (cmd_full),
    .cmd_wr_o     (cmd_wr),
    .cmd_ctrl_o   (front_ctrl),
    .cmd_digits_o (front_digits)
  );

  tlnef_fifo #(
    .Width(CmdW)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_wr),
    .wr_data_i ({front_ctrl, front_digits}),
    .full_o    (cmd_full),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_rd_data),
    .empty_o   (cmd_empty)
  );

  assign back_ctrl   = cmd_ctrl_t'(cmd_rd_data[CmdW-1:DigW]);
  assign back_digits = cmd_rd_data[DigW-1:0];
  assign full        = cmd_full;

  tlnef_back #(
    .NumberDigits(NUMBER_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!cmd_empty),
    .cmd_ctrl_i   (back_ctrl),
    .cmd_digits_i (back_digits),
    .cmd_pop_o    (cmd_pop),
    .out_full_i   (out_full),
    .out_wr_o     (out_wr),
    .out_item_o   (back_item)
  );

  tlnef_fifo #(
    .Width(OutW)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (out_wr),
    .wr_data_i (back_item),
    .full_o    (out_full),
    .rd_en_i   (pop),
    .rd_data_o (out_rd_data),
    .empty_o   (empty)
  );

  assign out_item_o = out_item_t'(out_rd_data);

endmodule

/* sv/tlnef_fifo.sv */
// Two-entry queue of flat words, used for commands and for result items.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tlnef_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_wr;
    rd_ptr_d = rd_ptr_q ^ do_rd;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count_q != 2'd3, "queue count beyond depth")
  `ASSERT_IMPLY(a_ptr_match, empty_o || full_o, wr_ptr_q == rd_ptr_q,
                "pointers disagree with count")

endmodule

/* sv/tlnef_front.sv */
// Front end: configuration registers, line state and byte classification.
// Depends on tlnef_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlnef_front #(
  parameter int unsigned NumberDigits = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tlnef_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [tlnef_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  input  tlnef_pkg::in_item_t                  in_item_i,
  input  logic                                 cmd_full_i,
  output logic                                 cmd_wr_o,
  output tlnef_pkg::cmd_ctrl_t                 cmd_ctrl_o,
  output logic [4*NumberDigits-1:0]            cmd_digits_o
);
  import tlnef_pkg::*;

  localparam int unsigned LnW = 4 * NumberDigits;
  localparam logic [LnW-1:0] LnOne = LnW'(1);

  cfg_t           cfg_q;
  logic           at_line_start_q, at_line_start_d;
  logic [1:0]     blank_run_q, blank_run_d;
  logic [LnW-1:0] line_number_q, line_number_d;

  logic           accept;
  logic [7:0]     c;
  logic           is_nl, als_eff, numbered, dollar, drop, esc;
  logic [LnW-1:0] ln_eff, ln_inc;
  logic           all_nine, carry;
  cmd_ctrl_t      ctrl;

  assign accept = in_valid_i && !cmd_full_i;
  assign c      = in_item_i.in_byte;
  assign is_nl  = (c == ChNewline);
  assign als_eff = in_item_i.new_file || at_line_start_q;
  assign ln_eff  = in_item_i.new_file ? LnOne : line_number_q;

  // Decimal increment, held at all nines.
  always_comb begin
    ln_inc   = ln_eff;
    all_nine = 1'b1;
    carry    = 1'b1;
    for (int p = 0; p < NumberDigits; p++) begin
      all_nine = all_nine && (ln_eff[4*p +: 4] == BcdNine);
      if (carry) begin
        if (ln_eff[4*p +: 4] == BcdNine) begin
          ln_inc[4*p +: 4] = 4'd0;
        end else begin
          ln_inc[4*p +: 4] = ln_eff[4*p +: 4] + 4'd1;
          carry            = 1'b0;
        end
      end
    end
    if (all_nine) begin
      ln_inc = ln_eff;
    end
  end

  always_comb begin
    numbered = (cfg_q.number_nonblank && als_eff && !is_nl) ||
               (cfg_q.number_all && !cfg_q.number_nonblank && als_eff &&
                !(cfg_q.squeeze_blank && blank_run_q > 2'd1));
    dollar   = is_nl && cfg_q.show_ends &&
               (!cfg_q.squeeze_blank || blank_run_q == 2'd0);

    if (is_nl) begin
      blank_run_d = (als_eff && blank_run_q < 2'd2) ? blank_run_q + 2'd1 : blank_run_q;
    end else begin
      blank_run_d = 2'd0;
    end
    at_line_start_d = is_nl;
    line_number_d   = numbered ? ln_inc : ln_eff;
    drop            = cfg_q.squeeze_blank && blank_run_d > 2'd1 && is_nl;

    if (c == ChTab) begin
      esc = cfg_q.show_tabs;
    end else begin
      esc = cfg_q.show_nonprinting &&
            ((c <= CtrlMax && !is_nl) || (c inside {[ChDelete:MetaMax]}));
    end

    ctrl.numbered = numbered;
    ctrl.dollar   = dollar;
    ctrl.payload  = c;
    if (drop) begin
      ctrl.kind = CH_NONE;
    end else if (!esc) begin
      ctrl.kind = CH_RAW;
    end else if (c <= CtrlMax) begin
      ctrl.kind    = CH_CARET;
      ctrl.payload = c + CaretOfs;
    end else if (c == ChDelete) begin
      ctrl.kind    = CH_CARET;
      ctrl.payload = ChQuery;
    end else begin
      ctrl.kind    = CH_META;
      ctrl.payload = c - CaretOfs;
    end
  end

  // A dropped newline with nothing else to show leaves no command.
  assign cmd_wr_o     = accept && (numbered || dollar || ctrl.kind != CH_NONE);
  assign cmd_ctrl_o   = ctrl;
  assign cmd_digits_o = ln_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q           <= '0;
      at_line_start_q <= 1'b1;
      blank_run_q     <= 2'd0;
      line_number_q   <= LnOne;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_data_i[0];
          CFG_NUMBER_ALL:       cfg_q.number_all       <= cfg_data_i[0];
          CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data_i[0];
          CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data_i[0];
          CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data_i[0];
          CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        at_line_start_q <= at_line_start_d;
        blank_run_q     <= blank_run_d;
        line_number_q   <= line_number_d;
      end
    end
  end

  `ASSERT_ALWAYS(a_blank_run_sat, blank_run_q != 2'd3, "blank run beyond saturation")
  `ASSERT_NEXT(a_nl_sets_start, accept && is_nl, at_line_start_q,
               "newline did not set line start")

endmodule

/* sv/tlnef_back.sv */
// Back end: expands one command into its output bytes, one per cycle while out_full_i is low.
// Depends on tlnef_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlnef_back #(
  parameter int unsigned NumberDigits = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  tlnef_pkg::cmd_ctrl_t      cmd_ctrl_i,
  input  logic [4*NumberDigits-1:0] cmd_digits_i,
  output logic                      cmd_pop_o,
  input  logic                      out_full_i,
  output logic                      out_wr_o,
  output tlnef_pkg::out_item_t      out_item_o
);
  import tlnef_pkg::*;

  localparam int unsigned NumLen  = NumberDigits + 1;
  localparam int unsigned CntW    = $clog2(NumberDigits + 7);
  localparam int unsigned NumIdxW = $clog2(NumLen);
  localparam logic [CntW-1:0] NumLenC = CntW'(NumLen);

  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] total, char_len, j, m;
  logic [7:0]      num_bytes [NumLen];
  logic            zero_above [NumberDigits];
  logic [7:0]      byte_sel, char_byte;
  logic            fire, is_last;

  // Number field: space-padded digits, most significant first, then a tab.
  always_comb begin
    zero_above[NumberDigits-1] = (cmd_digits_i[4*(NumberDigits-1) +: 4] == 4'd0);
    for (int p = int'(NumberDigits) - 2; p >= 0; p--) begin
      zero_above[p] = (cmd_digits_i[4*p +: 4] == 4'd0) && zero_above[p+1];
    end
    for (int i = 0; i < NumberDigits; i++) begin
      if (zero_above[NumberDigits-1-i] && i != NumberDigits - 1) begin
        num_bytes[i] = ChSpace;
      end else begin
        num_bytes[i] = ChZero | {4'd0, cmd_digits_i[4*(NumberDigits-1-i) +: 4]};
      end
    end
    num_bytes[NumberDigits] = ChTab;
  end

  always_comb begin
    case (cmd_ctrl_i.kind)
      CH_RAW:   char_len = CntW'(1);
      CH_CARET: char_len = CntW'(2);
      CH_META:  char_len = CntW'(4);
      default:  char_len = '0;
    endcase
    total = (cmd_ctrl_i.numbered ? NumLenC : '0) + CntW'(cmd_ctrl_i.dollar) + char_len;
    j     = idx_q - (cmd_ctrl_i.numbered ? NumLenC : '0);
    m     = j - CntW'(cmd_ctrl_i.dollar);

    case (cmd_ctrl_i.kind)
      CH_CARET: char_byte = (m[1:0] == 2'd0) ? ChCaret : cmd_ctrl_i.payload;
      CH_META: begin
        case (m[1:0])
          2'd0:    char_byte = ChUpperM;
          2'd1:    char_byte = ChDash;
          2'd2:    char_byte = ChCaret;
          default: char_byte = cmd_ctrl_i.payload;
        endcase
      end
      default:  char_byte = cmd_ctrl_i.payload;
    endcase

    if (cmd_ctrl_i.numbered && idx_q < NumLenC) begin
      byte_sel = num_bytes[idx_q[NumIdxW-1:0]];
    end else if (cmd_ctrl_i.dollar && j == '0) begin
      byte_sel = ChDollar;
    end else begin
      byte_sel = char_byte;
    end
  end

  assign fire    = cmd_valid_i && !out_full_i;
  assign is_last = (idx_q == total - CntW'(1));

  assign out_wr_o            = fire;
  assign out_item_o.out_byte = byte_sel;
  assign out_item_o.last     = is_last;
  assign cmd_pop_o           = fire && is_last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = is_last ? '0 : idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  `ASSERT_IMPLY(a_idx_in_cmd, cmd_valid_i, idx_q < total, "byte index past command length")
  `ASSERT_IMPLY(a_idle_idx, !cmd_valid_i, idx_q == '0, "byte index left over without command")

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for text_line_number_escape_filter_unit.
// Predicts each formatted byte from its own copy of the line state; needs tlnef_pkg and the RTL.
module tb_top;
  import tlnef_pkg::*;

  localparam int unsigned NumDigits    = 6;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned RandPhases   = 4;
  localparam int unsigned CfgPerPhase  = 2;
  localparam int unsigned ItemsPerCfg  = 41;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                push;
  logic                full;
  in_item_t            in_item_i;
  logic                empty;
  logic                pop;
  out_item_t           out_item_o;

  text_line_number_escape_filter_unit #(
    .NUMBER_DIGITS(NumDigits)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o)
  );

  // Mirror of the block's settings and line state
  cfg_t                   model_cfg     = '0;
  logic                   at_line_start = 1'b1;
  logic [1:0]             blank_run     = 2'd0;
  logic [4*NumDigits-1:0] line_bcd      = (4*NumDigits)'(1);

  logic [7:0] fmt_buf[$];
  out_item_t  formatted_q[$];
  out_item_t  oldest_fmt;

  int unsigned errors         = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (formatted_q.size() == 0) begin
        $error("out_byte: expected nothing, got %0d", out_item_o.out_byte);
        errors++;
      end else begin
        oldest_fmt = formatted_q.pop_front();
        if (out_item_o.out_byte !== oldest_fmt.out_byte) begin
          $error("out_byte: expected %0d, got %0d", oldest_fmt.out_byte, out_item_o.out_byte);
          errors++;
        end
        if (out_item_o.last !== oldest_fmt.last) begin
          $error("last: expected %0d, got %0d", oldest_fmt.last, out_item_o.last);
          errors++;
        end
      end
    end
  end

  // Print the line number space-padded, then a tab; advance unless saturated
  task automatic print_line_number();
    logic [3:0] digit;
    logic       lead;
    logic       carry;
    int         d;
    lead = 1'b1;
    for (d = NumDigits - 1; d >= 0; d--) begin
      digit = line_bcd[4*d +: 4];
      lead  = lead && (digit == 4'd0) && (d != 0);
      fmt_buf.push_back(lead ? ChSpace : ChZero + {4'd0, digit});
    end
    fmt_buf.push_back(ChTab);
    if (line_bcd != {NumDigits{BcdNine}}) begin
      carry = 1'b1;
      for (d = 0; d < NumDigits; d++) begin
        if (carry) begin
          if (line_bcd[4*d +: 4] == BcdNine) begin
            line_bcd[4*d +: 4] = 4'd0;
          end else begin
            line_bcd[4*d +: 4] = line_bcd[4*d +: 4] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
  endtask

  // Work out every formatted byte one input item causes and queue them
  task automatic format_byte(input in_item_t it);
    logic [7:0] c;
    logic       esc;
    int         k;
    c = it.in_byte;
    fmt_buf.delete();
    if (it.new_file) begin
      line_bcd      = (4*NumDigits)'(1);
      at_line_start = 1'b1;
    end
    if (model_cfg.number_nonblank && at_line_start && c != ChNewline) begin
      print_line_number();
    end
    if (model_cfg.number_all && !model_cfg.number_nonblank && at_line_start &&
        !(model_cfg.squeeze_blank && blank_run > 2'd1)) begin
      print_line_number();
    end
    if (c == ChNewline) begin
      if (model_cfg.show_ends && (!model_cfg.squeeze_blank || blank_run == 2'd0)) begin
        fmt_buf.push_back(ChDollar);
      end
      if (at_line_start && blank_run < 2'd2) begin
        blank_run = blank_run + 2'd1;
      end
      at_line_start = 1'b1;
    end else begin
      at_line_start = 1'b0;
      blank_run     = 2'd0;
    end
    // Drop a newline inside a squeezed run of blank lines
    if (!(model_cfg.squeeze_blank && blank_run > 2'd1 && c == ChNewline)) begin
      esc = 1'b0;
      if (c == ChTab) begin
        esc = model_cfg.show_tabs;
      end else if (model_cfg.show_nonprinting) begin
        esc = (c <= CtrlMax && c != ChNewline) || (c >= ChDelete && c <= MetaMax);
      end
      if (!esc) begin
        fmt_buf.push_back(c);
      end else if (c <= CtrlMax) begin
        fmt_buf.push_back(ChCaret);
        fmt_buf.push_back(c + CaretOfs);
      end else if (c == ChDelete) begin
        fmt_buf.push_back(ChCaret);
        fmt_buf.push_back(ChQuery);
      end else begin
        fmt_buf.push_back(ChUpperM);
        fmt_buf.push_back(ChDash);
        fmt_buf.push_back(ChCaret);
        fmt_buf.push_back(c - CaretOfs);
      end
    end
    for (k = 0; k < fmt_buf.size(); k++) begin
      formatted_q.push_back('{out_byte: fmt_buf[k], last: (k == fmt_buf.size() - 1)});
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic nf);
    in_item_t it;
    it.in_byte  = b;
    it.new_file = nf;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push      <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    format_byte(it);
  endtask

  // Hold the input until every formatted byte is out, then let the pipe settle
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (formatted_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  task automatic apply_config(input cfg_t c);
    drain();
    write_reg(CFG_NUMBER_NONBLANK,  c.number_nonblank);
    write_reg(CFG_NUMBER_ALL,       c.number_all);
    write_reg(CFG_SHOW_ENDS,        c.show_ends);
    write_reg(CFG_SHOW_TABS,        c.show_tabs);
    write_reg(CFG_SQUEEZE_BLANK,    c.squeeze_blank);
    write_reg(CFG_SHOW_NONPRINTING, c.show_nonprinting);
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    model_cfg = c;
  endtask

  function automatic logic [7:0] rand_text_byte();
    case ($urandom_range(9))
      0, 1, 2: return ChNewline;
      3:       return ChTab;
      4:       return 8'($urandom_range(31));
      5:       return 8'($urandom_range(159, 127));
      6:       return 8'($urandom_range(255));
      default: return 8'($urandom_range(126, 32));
    endcase
  endfunction

  task automatic test_plain_passthrough();
    apply_config('0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(ChTab, 1'b0);
    send_item(ChNewline, 1'b0);
  endtask

  task automatic test_escape_notation();
    apply_config('1);
    send_item(8'd0, 1'b1);
    send_item(ChTab, 1'b0);
    send_item(CtrlMax, 1'b0);
    send_item(ChDelete, 1'b0);
    send_item(8'd128, 1'b0);
    send_item(MetaMax, 1'b0);
    send_item(8'd160, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd126, 1'b0);
    send_item(ChNewline, 1'b0);
    send_item(ChNewline, 1'b0);
  endtask

  task automatic test_tab_nonprinting_only();
    cfg_t c;
    c = '0;
    c.show_nonprinting = 1'b1;
    apply_config(c);
    send_item(ChTab, 1'b0);
    send_item(8'd1, 1'b0);
  endtask

  task automatic test_number_squeeze();
    cfg_t c;
    c = '0;
    c.number_all    = 1'b1;
    c.squeeze_blank = 1'b1;
    c.show_ends     = 1'b1;
    apply_config(c);
    send_item("a", 1'b1);
    send_item(ChNewline, 1'b0);
    send_item(ChNewline, 1'b0);
    send_item(ChNewline, 1'b0);
    send_item(ChNewline, 1'b0);
    send_item("b", 1'b1);
    send_item(ChNewline, 1'b0);
  endtask

  // Text-like stream under changing settings, sender idling and receiver stalls; each config change drains first
  task automatic test_random_stream();
    int   p;
    int   s;
    int   n;
    cfg_t c;
    for (p = 0; p < RandPhases; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (s = 0; s < CfgPerPhase; s++) begin
        c = (p == 0 && s == 0) ? cfg_t'('1) : cfg_t'(6'($urandom_range(63)));
        apply_config(c);
        for (n = 0; n < ItemsPerCfg; n++) begin
          send_item(rand_text_byte(), ($urandom_range(19) == 0));
        end
      end
    end
  endtask

  initial begin
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    push       = 1'b0;
    pop        = 1'b0;
    in_item_i  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_plain_passthrough();
    test_escape_notation();
    test_tab_nonprinting_only();
    test_number_squeeze();
    test_random_stream();
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
